// ===== rtl/utf8cjk_pkg.sv =====
// Shared types, constants and decode helpers for the UTF-8 CJK detector.
// No dependencies; used by utf8cjk_decode and utf8_cjk_detector_top.
package utf8cjk_pkg;

   localparam int HeldDepth = 3;
   localparam int CpWidth   = 21;

   localparam logic [CpWidth-1:0] CjkSymLo  = 21'h03000;
   localparam logic [CpWidth-1:0] CjkSymHi  = 21'h0303f;
   localparam logic [CpWidth-1:0] CjkExtALo = 21'h03400;
   localparam logic [CpWidth-1:0] CjkExtAHi = 21'h04dbf;
   localparam logic [CpWidth-1:0] CjkUniLo  = 21'h04e00;
   localparam logic [CpWidth-1:0] CjkUniHi  = 21'h09fff;
   localparam logic [CpWidth-1:0] CjkCompLo = 21'h0f900;
   localparam logic [CpWidth-1:0] CjkCompHi = 21'h0faff;
   localparam logic [CpWidth-1:0] CjkFullLo = 21'h0ff00;
   localparam logic [CpWidth-1:0] CjkFullHi = 21'h0ffef;

   localparam logic [2:0] LenSkip  = 3'd0;
   localparam logic [2:0] LenAscii = 3'd1;
   localparam logic [2:0] LenTwo   = 3'd2;
   localparam logic [2:0] LenThree = 3'd3;
   localparam logic [2:0] LenFour  = 3'd4;

   typedef logic [HeldDepth-1:0][7:0] held_type;

   typedef struct packed {
      held_type   held;
      logic [1:0] count;
   } dec_state_type;

   typedef struct packed {
      dec_state_type nxt;
      logic          hit;
   } dec_result_type;

   function automatic logic [2:0] seq_length(input logic [7:0] b);
      logic [2:0] n;
      priority if (b[7] == 1'b0)       n = LenAscii;
      else if (b[7:5] == 3'b110)       n = LenTwo;
      else if (b[7:4] == 4'b1110)      n = LenThree;
      else if (b[7:3] == 5'b11110)     n = LenFour;
      else                             n = LenSkip;
      return n;
   endfunction

   function automatic logic in_cjk(input logic [CpWidth-1:0] cp);
      return (cp >= CjkSymLo  && cp <= CjkSymHi)  ||
             (cp >= CjkExtALo && cp <= CjkExtAHi) ||
             (cp >= CjkUniLo  && cp <= CjkUniHi)  ||
             (cp >= CjkCompLo && cp <= CjkCompHi) ||
             (cp >= CjkFullLo && cp <= CjkFullHi);
   endfunction

endpackage

// ===== rtl/utf8_cjk_detector_top.sv =====
// UTF-8 CJK detector top level: input register, decode step, result register.
// rsp_valid is registered: it rises when the final byte leaves the input register.
// Throughput: one byte per cycle unless stalled; the decode step is utf8cjk_decode.
// A stalled result holds the pipeline only through the single input register.
// Reset (synchronous) clears the held sequence, the sticky flag and both valids.
// Depends on utf8cjk_pkg and utf8cjk_decode.
module utf8_cjk_detector_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_text_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_has_cjk
);

   logic                        in_valid_ff, in_valid_in;
   logic [7:0]                  in_byte_ff;
   logic                        in_last_ff;
   utf8cjk_pkg::dec_state_type  state_ff, state_in;
   logic                        found_ff, found_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_has_cjk_ff, rsp_has_cjk_in;
   utf8cjk_pkg::dec_result_type dec_res;
   logic                        out_free;
   logic                        advance;
   logic                        accept;

   utf8cjk_decode u_decode (
      .cur       (state_ff),
      .text_byte (in_byte_ff),
      .res       (dec_res)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_valid_in    = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      state_in       = state_ff;
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_has_cjk_in = rsp_has_cjk_ff;
      if (advance) begin
         if (in_last_ff) begin
            state_in       = '0;
            found_in       = 1'b0;
            rsp_valid_in   = 1'b1;
            rsp_has_cjk_in = found_ff | dec_res.hit;
         end else begin
            state_in = dec_res.nxt;
            found_in = found_ff | dec_res.hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_text_byte;
         in_last_ff <= req_last_byte;
      end
      rsp_has_cjk_ff <= rsp_has_cjk_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_has_cjk = rsp_has_cjk_ff;

   // end of string leaves the decoder clean
   assert property (@(posedge clock) disable iff (reset)
      (advance && in_last_ff) |=> (state_ff.count == 2'd0 && !found_ff))
      else $error("state not cleared after final byte");

   // a result only appears after a final byte went through the decode step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && in_last_ff))
      else $error("result without final byte");

   // held bytes always start with a multi-byte lead longer than the count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.count != 2'd0) |->
         (utf8cjk_pkg::seq_length(state_ff.held[0]) > {1'b0, state_ff.count}))
      else $error("held sequence without a valid lead");

   // a pending result is never overwritten while stalled
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !advance)
      else $error("decode step advanced into a stalled result");

endmodule

// ===== rtl/utf8cjk_decode.sv =====
// Combinational decode step: merges one byte into the held sequence,
// decodes a completed sequence and checks it. Depends on utf8cjk_pkg.
module utf8cjk_decode (
   input  utf8cjk_pkg::dec_state_type  cur,
   input  logic [7:0]                  text_byte,
   output utf8cjk_pkg::dec_result_type res
);

   logic [7:0]                     seq0, seq1, seq2, seq3;
   logic [2:0]                     lead_len;
   logic [2:0]                     len;
   logic                           skip_alone;
   logic                           complete;
   logic [utf8cjk_pkg::CpWidth-1:0] cp;

   always_comb begin
      seq0 = (cur.count == 2'd0) ? text_byte : cur.held[0];
      seq1 = (cur.count > 2'd1) ? cur.held[1] : ((cur.count == 2'd1) ? text_byte : 8'h00);
      seq2 = (cur.count > 2'd2) ? cur.held[2] : ((cur.count == 2'd2) ? text_byte : 8'h00);
      seq3 = (cur.count == 2'd3) ? text_byte : 8'h00;
   end

   assign lead_len   = utf8cjk_pkg::seq_length(seq0);
   assign len        = {1'b0, cur.count} + 3'd1;
   assign skip_alone = (cur.count == 2'd0) && (lead_len < utf8cjk_pkg::LenTwo);
   assign complete   = !skip_alone && (len >= utf8cjk_pkg::LenTwo) && (len == lead_len);

   always_comb begin
      unique case (lead_len)
         utf8cjk_pkg::LenTwo:
            cp = {10'd0, seq0[4:0], seq1[5:0]};
         utf8cjk_pkg::LenThree:
            cp = {5'd0, seq0[3:0], seq1[5:0], seq2[5:0]};
         utf8cjk_pkg::LenFour:
            cp = {seq0[2:0], seq1[5:0], seq2[5:0], seq3[5:0]};
         default:
            cp = '0;
      endcase
   end

   // an unfinished sequence at string end leaves at most a 2-byte residue,
   // whose codepoint is below every CJK range, so the flush adds no hit
   always_comb begin
      res.hit = complete && utf8cjk_pkg::in_cjk(cp);
      if (skip_alone || complete) begin
         res.nxt.held  = '0;
         res.nxt.count = 2'd0;
      end else begin
         res.nxt.held[0] = seq0;
         res.nxt.held[1] = seq1;
         res.nxt.held[2] = seq2;
         res.nxt.count   = len[1:0];
      end
   end

endmodule

// ===== tb/utf8_cjk_detector_top_tb.sv =====
// Self-checking testbench for utf8_cjk_detector_top: sends byte strings, predicts
// the per-string CJK flag and checks every result in order.
// Depends only on the RTL (utf8_cjk_detector_top with utf8cjk_decode and utf8cjk_pkg).

class cjk_scoreboard;
   bit [2:0][7:0] held;
   int unsigned   held_cnt;
   bit            found;
   bit            cjk_flags_due [$];
   int unsigned   errors;
   int unsigned   strings;
   int unsigned   flags_seen;
   int unsigned   hits;

   function void clear();
      held     = '0;
      held_cnt = 0;
      found    = 1'b0;
   endfunction

   function int lead_len(bit [7:0] b);
      if (b[7] == 1'b0) return 1;
      if (b[7:5] == 3'b110) return 2;
      if (b[7:4] == 4'b1110) return 3;
      if (b[7:3] == 5'b11110) return 4;
      return 0;
   endfunction

   function bit cp_is_cjk(int unsigned cp);
      return (cp >= 'h3000 && cp <= 'h303f) || (cp >= 'h3400 && cp <= 'h4dbf) ||
             (cp >= 'h4e00 && cp <= 'h9fff) || (cp >= 'hf900 && cp <= 'hfaff) ||
             (cp >= 'hff00 && cp <= 'hffef);
   endfunction

   function bit seq_hit(bit [3:0][7:0] s, int first, int n);
      int unsigned cp;
      int          k;
      cp = (n == 2) ? (s[first] & 8'h1f) : (n == 3) ? (s[first] & 8'h0f) : (s[first] & 8'h07);
      for (k = 1; k < n; k++)
         cp = (cp << 6) | (s[first+k] & 8'h3f);
      return cp_is_cjk(cp);
   endfunction

   function void note_byte(bit [7:0] b, bit last);
      bit [3:0][7:0] seq;
      int            len;
      int            i;
      int            n;
      seq            = {8'h00, held};
      seq[held_cnt]  = b;
      len            = held_cnt + 1;
      if (held_cnt == 0 && lead_len(b) < 2) begin
         len = 0;
      end else if (len >= 2 && len == lead_len(seq[0])) begin
         if (seq_hit(seq, 0, len)) found = 1'b1;
         len = 0;
      end
      if (last) begin
         // string ended mid-sequence: drop the lead, rescan what follows it
         i = 0;
         while (i < len) begin
            n = lead_len(seq[i]);
            if (n >= 2 && i + n <= len) begin
               if (seq_hit(seq, i, n)) found = 1'b1;
               i += n;
            end else begin
               i++;
            end
         end
         cjk_flags_due.push_back(found);
         strings++;
         if (found) hits++;
         clear();
      end else begin
         held = '0;
         for (i = 0; i < len; i++) held[i] = seq[i];
         held_cnt = len;
      end
   endfunction

   function void check_flag(bit got);
      bit want;
      flags_seen++;
      if (cjk_flags_due.size() == 0) begin
         $error("has_cjk: result with no string pending, got %0d", got);
         errors++;
      end else begin
         want = cjk_flags_due.pop_front();
         if (want != got) begin
            $error("has_cjk mismatch: expected %0d, got %0d", want, got);
            errors++;
         end
      end
   endfunction

   function int unsigned pending();
      return cjk_flags_due.size();
   endfunction
endclass

module utf8_cjk_detector_top_tb;
   localparam int unsigned CycleLimit = 200000;
   localparam int unsigned ByteTarget = 1250;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_text_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_has_cjk;

   cjk_scoreboard sb = new;
   logic [7:0]    str_bytes [$];
   int unsigned   bytes_sent = 0;
   int unsigned   cycles = 0;
   bit            calm = 1'b0;

   function automatic int unsigned urandom_pct();
      return $urandom_range(0, 99);
   endfunction

   utf8_cjk_detector_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_text_byte (req_text_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_has_cjk   (rsp_has_cjk)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAIL utf8_cjk_detector_top");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && !calm && (urandom_pct() < 7);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_flag(rsp_has_cjk);
   end

   task automatic send_txn(input logic [7:0] b, input logic last);
      if (!calm && urandom_pct() < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      req_last_byte <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(b, last);
      bytes_sent++;
      calm = (bytes_sent >= 500 && bytes_sent < 800);
   endtask

   task automatic send_string();
      int i;
      for (i = 0; i < str_bytes.size(); i++)
         send_txn(str_bytes[i], i == str_bytes.size() - 1);
   endtask

   task automatic push_cp(input int unsigned cp);
      if (cp < 'h80) begin
         str_bytes.push_back(cp[7:0]);
      end else if (cp < 'h800) begin
         str_bytes.push_back({3'b110, cp[10:6]});
         str_bytes.push_back({2'b10, cp[5:0]});
      end else if (cp < 'h10000) begin
         str_bytes.push_back({4'b1110, cp[15:12]});
         str_bytes.push_back({2'b10, cp[11:6]});
         str_bytes.push_back({2'b10, cp[5:0]});
      end else begin
         str_bytes.push_back({5'b11110, cp[20:18]});
         str_bytes.push_back({2'b10, cp[17:12]});
         str_bytes.push_back({2'b10, cp[11:6]});
         str_bytes.push_back({2'b10, cp[5:0]});
      end
   endtask

   function automatic int unsigned pick_cjk_cp();
      int unsigned lo;
      int unsigned hi;
      case ($urandom_range(0, 4))
         0: begin lo = 'h3000; hi = 'h303f; end
         1: begin lo = 'h3400; hi = 'h4dbf; end
         2: begin lo = 'h4e00; hi = 'h9fff; end
         3: begin lo = 'hf900; hi = 'hfaff; end
         default: begin lo = 'hff00; hi = 'hffef; end
      endcase
      case ($urandom_range(0, 9))
         0: return lo;
         1: return hi;
         2: return lo - 1;
         3: return hi + 1;
         default: return $urandom_range(lo, hi);
      endcase
   endfunction

   task automatic build_random_string();
      int          units;
      int          u;
      int unsigned roll;
      logic [7:0]  tweak;
      str_bytes.delete();
      units = $urandom_range(1, 5);
      for (u = 0; u < units; u++) begin
         roll = urandom_pct();
         if (roll < 35) push_cp(pick_cjk_cp());
         else if (roll < 50) push_cp($urandom_range('h800, 'hffff));
         else if (roll < 60) push_cp($urandom_range('h80, 'h7ff));
         else if (roll < 68) push_cp($urandom_range('h10000, 'h1fffff));
         else if (roll < 80) push_cp($urandom_range(1, 127));
         else if (roll < 90) str_bytes.push_back(8'($urandom_range(1, 255)));
         else begin
            push_cp(pick_cjk_cp());
            repeat ($urandom_range(1, 2)) void'(str_bytes.pop_back());
         end
         // lenient decode: following bytes need not look like continuations
         if (urandom_pct() < 10) begin
            tweak = {2'($urandom_range(0, 3)), str_bytes[str_bytes.size()-1][5:0]};
            if (tweak != 8'h00) str_bytes[str_bytes.size()-1] = tweak;
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      str_bytes = {8'h41};                                   send_string();
      str_bytes = {8'hff};                                   send_string();
      str_bytes = {8'h80, 8'he3, 8'h80, 8'h80};              send_string();
      str_bytes = {8'he3, 8'h81, 8'h80};                     send_string();
      str_bytes = {8'hc2, 8'h80, 8'hf0, 8'h9f, 8'h98, 8'h80}; send_string();
      str_bytes = {8'hef, 8'hbf, 8'haf};                     send_string();
      str_bytes = {8'hf8, 8'he4, 8'h41};                     send_string();
      str_bytes = {8'hf0, 8'hc5, 8'ha0};                     send_string();

      while (bytes_sent < ByteTarget) begin
         build_random_string();
         send_string();
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in %0d strings; %0d flags checked, %0d strings hit CJK.",
               bytes_sent, sb.strings, sb.flags_seen, sb.hits);
      if (sb.errors == 0) $display("PASS utf8_cjk_detector_top");
      else $display("FAIL utf8_cjk_detector_top");
      $finish;
   end
endmodule
